[src/wiegand_frame_transmitter_unit_macros.svh]
// Assertion macros shared by the Wiegand transmitter RTL.
// Expects a clock i_clk and an active-low reset i_rst_n in the including scope.
`ifndef WIEGAND_FRAME_TRANSMITTER_UNIT_MACROS_SVH
`define WIEGAND_FRAME_TRANSMITTER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define WFT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define WFT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/wft_pkg.sv]
// Shared types and constants of the Wiegand 26/34 bit transmitter.
// No dependencies; compiled before the interfaces and the top level.
package wft_pkg;

    localparam int unsigned DATA_W     = 32;
    localparam int unsigned FRAME_W    = 34;
    localparam int unsigned COUNT_W    = 6;
    localparam int unsigned PULSE_W    = 16;
    localparam int unsigned GAP_W      = 16;
    localparam int unsigned FGAP_W     = 20;
    localparam int unsigned CFG_ADDR_W = 2;
    localparam int unsigned CFG_DATA_W = 20;

    localparam logic [COUNT_W-1:0] BITS_WIDE   = 6'd34;
    localparam logic [COUNT_W-1:0] BITS_NARROW = 6'd26;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_PULSE_TICKS     = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_BIT_GAP_TICKS   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_GAP_TICKS = 2'd2;

    localparam logic [PULSE_W-1:0] PULSE_RESET = 16'd10;
    localparam logic [GAP_W-1:0]   GAP_RESET   = 16'd100;
    localparam logic [FGAP_W-1:0]  FGAP_RESET  = 20'd10000;

    // Input command codes
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PULSE = 2'd1,
        PH_GAP   = 2'd2,
        PH_FRAME = 2'd3
    } t_phase;

endpackage

[src/wft_if.sv]
// Handshake channel interfaces of the Wiegand transmitter: input items,
// result items and configuration writes. Depends on wft_pkg.
interface wft_in_if;
    import wft_pkg::*;
    logic              valid;
    logic              ready;
    logic              command;
    logic [DATA_W-1:0] frame_data;
    logic              wide_format;

    modport source (output valid, command, frame_data, wide_format, input ready);
    modport sink   (input valid, command, frame_data, wide_format, output ready);
endinterface

interface wft_out_if;
    logic valid;
    logic ready;
    logic d0_line;
    logic d1_line;
    logic busy_res;
    logic load_rejected;

    modport source (output valid, d0_line, d1_line, busy_res, load_rejected, input ready);
    modport sink   (input valid, d0_line, d1_line, busy_res, load_rejected, output ready);
endinterface

interface wft_cfg_if;
    import wft_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

[src/wiegand_frame_transmitter_unit.sv]
// Wiegand 26/34 bit frame transmitter, top level.
// Depends on wft_pkg, the channel interfaces in wft_if.sv and the assertion macros header.
//
// Every input item (a time tick or a frame load) is taken and gives
// exactly one result item holding the D0/D1 levels, the busy flag and a reject flag,
// as they stand after that item. The item is handled by a single pass of logic
// that feeds the phase state and the result register together, so the block
// takes one item per clock; a full result register that the sink holds off stalls
// the input, and the input is ready again in the cycle the result is taken.
// A load while idle builds the frame (even parity over the first half of the
// payload, the payload, odd parity over the second half), left-aligns it, and
// starts the first pulse at once. A load while busy is dropped and flagged.
// Ticks count down pulse, bit gap and frame gap times set by the three
// configuration registers; a zero pulse or bit gap counts as one tick, a zero
// frame gap ends the frame right after the last bit gap, and a frame gap
// beyond the timer width saturates. Configuration writes take effect at once
// and are meant to be done while the block is idle.
`include "wiegand_frame_transmitter_unit_macros.svh"

module wiegand_frame_transmitter_unit #(
    parameter int unsigned TIMER_BITS = 20
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    wft_in_if.sink    i_in,
    wft_cfg_if.sink   i_cfg,
    wft_out_if.source o_out
);
    import wft_pkg::*;

    localparam logic [32:0] TIMER_MAX_EXT = (33'd1 << TIMER_BITS) - 33'd1;

    // Configuration registers
    logic [PULSE_W-1:0] r_pulse_ticks;
    logic [GAP_W-1:0]   r_bit_gap_ticks;
    logic [FGAP_W-1:0]  r_frame_gap_ticks;

    // Frame state
    logic [FRAME_W-1:0]    r_bit_shift, n_bit_shift;
    logic [COUNT_W-1:0]    r_bits_left, n_bits_left;
    t_phase                r_phase, n_phase;
    logic [TIMER_BITS-1:0] r_timer, n_timer;

    // Result register
    logic r_out_valid;
    logic r_d0, r_d1, r_busy, r_rejected;
    logic n_d0, n_d1, n_rejected;

    logic in_accept;
    logic out_accept;
    logic cfg_accept;

    logic [TIMER_BITS-1:0] pulse_len, gap_len, fgap_len;
    logic [TIMER_BITS-1:0] timer_dec;
    logic [FRAME_W-1:0]    load_frame;
    logic [COUNT_W-1:0]    bits_after;
    logic                  even_par, odd_par;

    // Transfer on the input whenever the result slot is free or draining now
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign in_accept   = i_in.valid && i_in.ready;
    assign out_accept  = o_out.valid && o_out.ready;
    assign i_cfg.ready = 1'b1;
    assign cfg_accept  = i_cfg.valid && i_cfg.ready;

    // Phase lengths: at least one tick for pulse and bit gap, saturate frame gap
    assign pulse_len = (r_pulse_ticks == '0) ? TIMER_BITS'(1) : TIMER_BITS'(r_pulse_ticks);
    assign gap_len   = (r_bit_gap_ticks == '0) ? TIMER_BITS'(1) : TIMER_BITS'(r_bit_gap_ticks);
    assign fgap_len  = (33'(r_frame_gap_ticks) > TIMER_MAX_EXT)
                       ? TIMER_MAX_EXT[TIMER_BITS-1:0]
                       : TIMER_BITS'(r_frame_gap_ticks);
    assign timer_dec = (r_timer != '0) ? (r_timer - TIMER_BITS'(1)) : r_timer;
    assign bits_after = (r_bits_left != '0) ? (r_bits_left - COUNT_W'(1)) : r_bits_left;

    // Frame assembly, left-aligned so the first bit to send sits at the top
    always_comb begin
        if (i_in.wide_format) begin
            even_par   = ^i_in.frame_data[31:16];
            odd_par    = ~^i_in.frame_data[15:0];
            load_frame = {even_par, i_in.frame_data, odd_par};
        end else begin
            even_par   = ^i_in.frame_data[23:12];
            odd_par    = ~^i_in.frame_data[11:0];
            load_frame = {even_par, i_in.frame_data[23:0], odd_par, 8'h00};
        end
    end

    // Next state for one item
    always_comb begin
        n_bit_shift = r_bit_shift;
        n_bits_left = r_bits_left;
        n_phase     = r_phase;
        n_timer     = r_timer;
        n_rejected  = 1'b0;
        if (i_in.command == CMD_LOAD) begin
            if (r_phase != PH_IDLE) begin
                n_rejected = 1'b1;
            end else begin
                n_bit_shift = load_frame;
                n_bits_left = i_in.wide_format ? BITS_WIDE : BITS_NARROW;
                n_phase     = PH_PULSE;
                n_timer     = pulse_len;
            end
        end else if (r_phase != PH_IDLE) begin
            n_timer = timer_dec;
            if (timer_dec == '0) begin
                case (r_phase)
                    PH_PULSE: begin
                        n_phase = PH_GAP;
                        n_timer = gap_len;
                    end
                    PH_GAP: begin
                        // advance to the next bit, or close the frame
                        n_bit_shift = {r_bit_shift[FRAME_W-2:0], 1'b0};
                        n_bits_left = bits_after;
                        if (bits_after != '0) begin
                            n_phase = PH_PULSE;
                            n_timer = pulse_len;
                        end else begin
                            n_timer = fgap_len;
                            n_phase = (fgap_len == '0) ? PH_IDLE : PH_FRAME;
                        end
                    end
                    PH_FRAME: begin
                        n_phase = PH_IDLE;
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end
    end

    // Line levels after the update: pull the line that matches the current bit
    always_comb begin
        n_d0 = 1'b1;
        n_d1 = 1'b1;
        case (n_phase)
            PH_PULSE: begin
                if (n_bit_shift[FRAME_W-1]) begin
                    n_d1 = 1'b0;
                end else begin
                    n_d0 = 1'b0;
                end
            end
            default: begin
                n_d0 = 1'b1;
                n_d1 = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_ticks     <= PULSE_RESET;
            r_bit_gap_ticks   <= GAP_RESET;
            r_frame_gap_ticks <= FGAP_RESET;
        end else if (cfg_accept) begin
            case (i_cfg.addr)
                REG_PULSE_TICKS:     r_pulse_ticks     <= i_cfg.data[PULSE_W-1:0];
                REG_BIT_GAP_TICKS:   r_bit_gap_ticks   <= i_cfg.data[GAP_W-1:0];
                REG_FRAME_GAP_TICKS: r_frame_gap_ticks <= i_cfg.data[FGAP_W-1:0];
                default: begin
                    // writes beyond the register list are dropped
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_shift <= '0;
            r_bits_left <= '0;
            r_phase     <= PH_IDLE;
            r_timer     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_bit_shift <= n_bit_shift;
                r_bits_left <= n_bits_left;
                r_phase     <= n_phase;
                r_timer     <= n_timer;
                r_out_valid <= 1'b1;
            end else if (out_accept) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload, loaded with each input transfer
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_d0       <= n_d0;
            r_d1       <= n_d1;
            r_busy     <= (n_phase != PH_IDLE);
            r_rejected <= n_rejected;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.d0_line       = r_d0;
    assign o_out.d1_line       = r_d1;
    assign o_out.busy_res      = r_busy;
    assign o_out.load_rejected = r_rejected;

    `WFT_ASSERT_NOW(a_idle_empty, r_phase == PH_IDLE, r_bits_left == '0, "idle with bits left")
    `WFT_ASSERT_NOW(a_timer_live, r_phase != PH_IDLE, r_timer != '0, "active phase with zero timer")
    `WFT_ASSERT_NEXT(a_busy_match, in_accept, r_busy == (r_phase != PH_IDLE), "busy flag mismatch")
    `WFT_ASSERT_NEXT(a_reject_hold, in_accept && r_rejected == 1'b0 && n_rejected, $stable(r_bit_shift) && $stable(r_timer), "rejected load changed state")
    `WFT_ASSERT_NOW(a_one_line, r_out_valid, r_d0 || r_d1, "both data lines pulled low")

endmodule
